FILE: rtl/baro_sensor_compensation_top_assert.svh
// Assertion macros for the barometer compensation block.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef BARO_SENSOR_COMPENSATION_TOP_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BARO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BARO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold on the cycle after each cycle with reset asserted.
`define BARO_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/baro_pkg.sv
`timescale 1ns / 1ps

package baro_pkg;

  localparam int CAL_W      = 48;
  localparam int RAW_W      = 20;
  localparam int DIV_BITS   = 64;
  localparam int DSR_W      = 31;
  localparam int FINE_OFFSET = 128000;
  localparam int NUM_SCALE  = 3125;
  localparam int P_BASE     = 1048576;

  localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
  localparam logic [1:0] REG_PRESS_A   = 2'd1;
  localparam logic [1:0] REG_PRESS_B   = 2'd2;
  localparam logic [1:0] REG_PRESS_C   = 2'd3;

  // Values that ride along with the division.
  typedef struct packed {
    logic [31:0] temp;
    logic        neg;
    logic        zero;
  } div_side_t;

endpackage

FILE: rtl/baro_div.sv
`timescale 1ns / 1ps

module baro_div import baro_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [DIV_BITS-1:0] in_dividend,
  input  logic [DSR_W-1:0]    in_divisor,
  input  div_side_t           in_side,
  output logic                out_vld,
  output logic [DIV_BITS-1:0] out_quotient,
  output div_side_t           out_side
);

  logic                vld_r  [DIV_BITS];
  logic [DSR_W-1:0]    rem_r  [DIV_BITS];
  logic [DIV_BITS-1:0] dvd_r  [DIV_BITS];
  logic [DSR_W-1:0]    dsr_r  [DIV_BITS];
  div_side_t           side_r [DIV_BITS];

  // One quotient bit per stage. The dividend shifts out at the top while
  // quotient bits shift in at the bottom of the same register.
  for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
    logic                vld_in;
    logic [DSR_W-1:0]    rem_in;
    logic [DIV_BITS-1:0] dvd_in;
    logic [DSR_W-1:0]    dsr_in;
    div_side_t           side_in;
    logic [DSR_W:0]      trial;
    logic [DSR_W+1:0]    diff;
    logic                ge;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign dvd_in  = in_dividend;
      assign dsr_in  = in_divisor;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign dvd_in  = dvd_r[i-1];
      assign dsr_in  = dsr_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign trial = {rem_in, dvd_in[DIV_BITS-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_in};
    assign ge    = !diff[DSR_W+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        dvd_r[i]  <= {dvd_in[DIV_BITS-2:0], ge};
        dsr_r[i]  <= dsr_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_vld      = vld_r[DIV_BITS-1];
  assign out_quotient = dvd_r[DIV_BITS-1];
  assign out_side     = side_r[DIV_BITS-1];

endmodule

FILE: rtl/baro_sensor_compensation_top.sv
`timescale 1ns / 1ps
// Barometer compensation pipeline.
// Input channel: in_valid / in_stall carry one word holding a raw 20-bit
// temperature and a raw 20-bit pressure reading. Output channel:
// out_valid / out_stall carry the temperature in 0.01 degC, the pressure in
// Pa and a flag that is set when the pressure divisor was zero (the
// pressure then reads 0).
// Calibration is loaded through cfg_we / cfg_index / cfg_data, three 16-bit
// coefficients per 48-bit register, and may only change while no word is
// in flight.
// An accepted input word reaches the output register through 11 stages
// of temperature and polynomial math, 64 stages of the signed divider
// (one quotient bit each) and 6 stages after it.
// Throughput is one word per cycle.
// A stalled output freezes the whole pipeline, and in_stall follows it in
// the same cycle; no word is dropped or repeated.
// Reset clears all valid bits and the calibration registers.
`include "baro_sensor_compensation_top_assert.svh"

module baro_sensor_compensation_top import baro_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CAL_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [RAW_W-1:0]   in_raw_temperature,
  input  logic [RAW_W-1:0]   in_raw_pressure,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_temperature_centi,
  output logic signed [31:0] out_pressure_pa,
  output logic               out_divisor_zero
);

  logic [CAL_W-1:0] cal_t_r, cal_pa_r, cal_pb_r, cal_pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t_r  <= '0;
      cal_pa_r <= '0;
      cal_pb_r <= '0;
      cal_pc_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_CAL: cal_t_r  <= cfg_data;
        REG_PRESS_A:  cal_pa_r <= cfg_data;
        REG_PRESS_B:  cal_pb_r <= cfg_data;
        REG_PRESS_C:  cal_pc_r <= cfg_data;
      endcase
    end
  end

  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = cal_t_r[15:0];
  assign t2 = $signed(cal_t_r[31:16]);
  assign t3 = $signed(cal_t_r[47:32]);
  assign p1 = cal_pa_r[15:0];
  assign p2 = $signed(cal_pa_r[31:16]);
  assign p3 = $signed(cal_pa_r[47:32]);
  assign p4 = $signed(cal_pb_r[15:0]);
  assign p5 = $signed(cal_pb_r[31:16]);
  assign p6 = $signed(cal_pb_r[47:32]);
  assign p7 = $signed(cal_pc_r[15:0]);
  assign p8 = $signed(cal_pc_r[31:16]);
  assign p9 = $signed(cal_pc_r[47:32]);

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Stage valid bits before and after the divider, bit k is stage k+1.
  logic [10:0] pre_vld_r;
  logic [4:0]  post_vld_r;

  // Temperature stages.
  logic signed [17:0] d1_r;
  logic signed [16:0] d2_r;
  logic [RAW_W-1:0]   ap_r [8];
  logic signed [33:0] m1_r, m2_r;
  logic signed [20:0] va_r;
  logic signed [35:0] m3_r;
  logic signed [31:0] fine_r;
  logic [31:0]        tp_r [6];
  logic signed [32:0] x1_r;

  // Pressure polynomial stages.
  logic [63:0]        sq_r;
  logic signed [48:0] q5_r, q2_r, q5b_r, q2b_r;
  logic [63:0]        a6_r, a3_r;
  logic [63:0]        x2_r, y_r;
  logic [63:0]        w_r, pn_r;
  logic signed [30:0] dv_r;
  logic [63:0]        num_r;
  logic [63:0]        ma_r;
  logic [DSR_W-1:0]   mb_r;
  div_side_t          side_r;

  // Stages after the divider.
  logic               dvld;
  logic [63:0]        dq;
  div_side_t          dside;
  div_side_t          side_pr [5];
  logic [63:0]        p_r, pa_r, pb_r, pc_r;
  logic [63:0]        ps_r, am_r, c_r, cb_r;
  logic [63:0]        ll_r;
  logic [31:0]        hl_r, lh_r;
  logic [63:0]        b_r, x2b_r, s_r;

  logic signed [31:0] out_temp_r, out_press_r;
  logic               out_zero_r;

  // Next-state values.
  logic signed [17:0] d1_nxt;
  logic signed [16:0] d2_nxt;
  logic signed [33:0] m1_nxt, m2_nxt;
  logic signed [19:0] sh2;
  logic signed [35:0] m3_nxt;
  logic signed [17:0] vb;
  logic signed [31:0] fine_nxt;
  logic [31:0]        t5;
  logic [31:0]        temp_nxt;
  logic signed [32:0] x1_nxt;
  logic signed [65:0] sq_full;
  logic signed [48:0] q5_nxt, q2_nxt;
  logic signed [79:0] a6_full, a3_full;
  logic [63:0]        x2_nxt, y_nxt;
  logic [20:0]        pr;
  logic [63:0]        w_nxt, pn_nxt;
  logic [79:0]        z_full;
  logic [75:0]        num_full;
  logic signed [30:0] dv_nxt;
  logic [63:0]        ma_nxt;
  logic [DSR_W-1:0]   mb_nxt;
  div_side_t          side_nxt;
  logic [63:0]        p_nxt, ps_nxt;
  logic signed [79:0] am_full, c_full;
  logic [63:0]        ll_nxt;
  logic [31:0]        hl_nxt, lh_nxt;
  logic [63:0]        b_nxt, x2b_nxt, s_nxt;
  logic [63:0]        r_fin;
  logic signed [31:0] press_nxt;

  always_comb begin
    d1_nxt   = {1'b0, in_raw_temperature[19:3]} - {1'b0, t1, 1'b0};
    d2_nxt   = {1'b0, in_raw_temperature[19:4]} - {1'b0, t1};
    m1_nxt   = d1_r * t2;
    m2_nxt   = d2_r * d2_r;
    sh2      = $signed(m2_r[31:12]);
    m3_nxt   = sh2 * t3;
    vb       = $signed(m3_r[31:14]);
    fine_nxt = 32'(va_r) + 32'(vb);
    t5       = fine_r + (fine_r << 2) + 32'd128;
    temp_nxt = 32'($signed(t5[31:8]));
    x1_nxt   = 33'(fine_r) - 33'(FINE_OFFSET);
    sq_full  = x1_r * x1_r;
    q5_nxt   = x1_r * p5;
    q2_nxt   = x1_r * p2;
    a6_full  = $signed(sq_r) * p6;
    a3_full  = $signed(sq_r) * p3;
    x2_nxt   = a6_r + (64'(q5b_r) << 17) + (64'(p4) << 35);
    y_nxt    = 64'($signed(a3_r) >>> 8) + (64'(q2b_r) << 12);
    pr       = 21'(P_BASE) - {1'b0, ap_r[7]};
    w_nxt    = y_r + (64'd1 << 47);
    pn_nxt   = (64'(pr) << 31) - x2_r;
    z_full   = w_r * p1;
    dv_nxt   = $signed(z_full[63:33]);
    num_full = pn_r * 12'(NUM_SCALE);
    ma_nxt   = num_r[63] ? (64'd0 - num_r) : num_r;
    mb_nxt   = dv_r[30] ? (31'd0 - dv_r) : dv_r;
    side_nxt.temp = tp_r[5];
    side_nxt.neg  = num_r[63] ^ dv_r[30];
    side_nxt.zero = (dv_r == 31'sd0);
    p_nxt    = dside.neg ? (64'd0 - dq) : dq;
    ps_nxt   = 64'($signed(p_r) >>> 13);
    am_full  = $signed(ps_nxt) * p9;
    c_full   = $signed(p_r) * p8;
    // Low 64 bits of am * ps from three 32-bit partial products.
    ll_nxt   = am_r[31:0] * ps_r[31:0];
    hl_nxt   = am_r[63:32] * ps_r[31:0];
    lh_nxt   = am_r[31:0] * ps_r[63:32];
    b_nxt    = ll_r + {hl_r + lh_r, 32'd0};
    x2b_nxt  = 64'($signed(cb_r) >>> 19);
    s_nxt    = pc_r + 64'($signed(b_r) >>> 25) + x2b_r;
    r_fin    = 64'($signed(s_r) >>> 8) + (64'(p7) << 4);
    press_nxt = side_pr[4].zero ? 32'sd0 : $signed(r_fin[39:8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r   <= '0;
      post_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pre_vld_r   <= {pre_vld_r[9:0], in_valid};
      post_vld_r  <= {post_vld_r[3:0], dvld};
      out_valid_r <= post_vld_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      ap_r[0] <= in_raw_pressure;
      for (int k = 1; k < 8; k++) begin
        ap_r[k] <= ap_r[k-1];
      end
      m1_r   <= m1_nxt;
      m2_r   <= m2_nxt;
      va_r   <= $signed(m1_r[31:11]);
      m3_r   <= m3_nxt;
      fine_r <= fine_nxt;
      tp_r[0] <= temp_nxt;
      for (int k = 1; k < 6; k++) begin
        tp_r[k] <= tp_r[k-1];
      end
      x1_r   <= x1_nxt;
      sq_r   <= sq_full[63:0];
      q5_r   <= q5_nxt;
      q2_r   <= q2_nxt;
      a6_r   <= a6_full[63:0];
      a3_r   <= a3_full[63:0];
      q5b_r  <= q5_r;
      q2b_r  <= q2_r;
      x2_r   <= x2_nxt;
      y_r    <= y_nxt;
      w_r    <= w_nxt;
      pn_r   <= pn_nxt;
      dv_r   <= dv_nxt;
      num_r  <= num_full[63:0];
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
      side_r <= side_nxt;

      p_r        <= p_nxt;
      side_pr[0] <= dside;
      pa_r       <= p_r;
      ps_r       <= ps_nxt;
      am_r       <= am_full[63:0];
      c_r        <= c_full[63:0];
      side_pr[1] <= side_pr[0];
      pb_r       <= pa_r;
      ll_r       <= ll_nxt;
      hl_r       <= hl_nxt;
      lh_r       <= lh_nxt;
      cb_r       <= c_r;
      side_pr[2] <= side_pr[1];
      pc_r       <= pb_r;
      b_r        <= b_nxt;
      x2b_r      <= x2b_nxt;
      side_pr[3] <= side_pr[2];
      s_r        <= s_nxt;
      side_pr[4] <= side_pr[3];

      out_temp_r  <= $signed(side_pr[4].temp);
      out_press_r <= press_nxt;
      out_zero_r  <= side_pr[4].zero;
    end
  end

  baro_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_vld       (pre_vld_r[10]),
    .in_dividend  (ma_r),
    .in_divisor   (mb_r),
    .in_side      (side_r),
    .out_vld      (dvld),
    .out_quotient (dq),
    .out_side     (dside)
  );

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_temp_r;
  assign out_pressure_pa       = out_press_r;
  assign out_divisor_zero      = out_zero_r;

  `BARO_ASSERT_IMP(a_zero_press, out_valid && out_divisor_zero, out_pressure_pa == 32'sd0, "pressure not cleared for zero divisor")
  `BARO_ASSERT_NXT(a_accept_load, in_valid && !in_stall, pre_vld_r[0], "accepted word did not enter the pipeline")
  `BARO_ASSERT_NXT(a_stall_hold, out_valid && out_stall, $stable(pre_vld_r) && $stable(post_vld_r), "pipeline moved under a stalled output")
  `BARO_ASSERT_RST(a_reset_empty, !out_valid && (pre_vld_r == 11'd0), "pipeline not empty after reset")

endmodule
